@@ sv/wpsd_pkg.sv @@
// wpsd_pkg: beat payload types, result kinds and chunk tags for the wav pcm decoder
// no dependencies; compile first
package wpsd_pkg;

    // one byte of the file per input beat
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } wpsd_byte_t;

    // one result per output beat
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic [1:0]         channels;
        logic [4:0]         bits_per_sample;
        logic [31:0]        sample_rate;
        logic [31:0]        frames_remaining;
    } wpsd_result_t;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // four-character tags, first character in the low byte
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // sign flip for offset-binary 8-bit samples
    localparam logic [7:0] PCM8_OFFSET = 8'h80;

endpackage

@@ sv/wpsd_stream_if.sv @@
// wpsd_stream_if: valid/ready channel carrying one payload per beat
// payload type comes in as a parameter, normally a struct from wpsd_pkg
interface wpsd_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/wav_pcm_stream_decoder_unit.sv @@
// wav_pcm_stream_decoder_unit: byte-serial riff/wave pcm parser
// depends on wpsd_pkg and wpsd_stream_if
//
// usage
//   byte_chan carries one file byte per beat plus a last_byte flag that marks
//   the end of the file; after that beat the parser starts over at the header.
//   result_chan carries at most one result per input beat: a header result when
//   the data chunk header is taken, one sample frame per whole frame, or an
//   error result on a bad tag, a bad fmt field or data before fmt.
// throughput
//   one byte per cycle while the receiver keeps up; every byte is parsed in the cycle it is
//   accepted and its result lands in the result register, shown on the next cycle.
// stall
//   byte_chan.ready is high while the result register is empty or being taken
//   in the same cycle; a stalled receiver holds the result and blocks input.
// reset
//   rst_n clears the parse state and the result valid flag, not the result payload; no clearing pass.
module wav_pcm_stream_decoder_unit
    import wpsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    wpsd_stream_if.sink   byte_chan,
    wpsd_stream_if.source result_chan
);

    // parser phases
    localparam logic [2:0] PH_RIFF  = 3'd0;
    localparam logic [2:0] PH_CHUNK = 3'd1;
    localparam logic [2:0] PH_FMT   = 3'd2;
    localparam logic [2:0] PH_SKIP  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_FAIL  = 3'd5;

    logic [2:0]   phase_reg, phase_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic [31:0]  tag_reg, tag_next;
    logic [31:0]  rem_reg, rem_next;
    logic [31:0]  fs_reg, fs_next;
    logic [1:0]   ch_reg, ch_next;
    logic [4:0]   bd_reg, bd_next;
    logic [31:0]  rate_reg, rate_next;
    logic [31:0]  budget_reg, budget_next;
    logic [15:0]  held_reg, held_next;
    logic         fpos_reg, fpos_next;
    logic         out_valid_reg;
    wpsd_result_t out_reg;

    logic         accept;
    logic [7:0]   b;
    logic [3:0]   pos;
    logic [31:0]  b_wide;
    logic [31:0]  tag_base;
    logic [31:0]  fs_base;
    logic [31:0]  tag_acc;
    logic [31:0]  fs_acc;
    logic [4:0]   fmt_sh;
    logic [1:0]   frame_sh;
    logic [15:0]  smp;
    logic         err;
    logic         hdr;
    logic         smp_out;
    wpsd_result_t res;

    // handshake: take a byte whenever the result slot frees up
    assign byte_chan.ready    = !out_valid_reg || result_chan.ready;
    assign accept             = byte_chan.valid && byte_chan.ready;
    assign result_chan.valid  = out_valid_reg;
    assign result_chan.payload = out_reg;

    assign b      = byte_chan.payload.byte_value;
    assign pos    = cnt_reg;
    assign b_wide = {24'd0, b};

    // parse one byte
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        tag_next    = tag_reg;
        rem_next    = rem_reg;
        fs_next     = fs_reg;
        ch_next     = ch_reg;
        bd_next     = bd_reg;
        rate_next   = rate_reg;
        budget_next = budget_reg;
        held_next   = held_reg;
        fpos_next   = fpos_reg;
        err         = 1'b0;
        hdr         = 1'b0;
        smp_out     = 1'b0;
        smp         = 16'd0;
        tag_base    = (pos == 4'd0) ? 32'd0 : tag_reg;
        fs_base     = (pos == 4'd0) ? 32'd0 : fs_reg;
        tag_acc     = tag_reg | (b_wide << {pos[1:0], 3'b000});
        fs_acc      = 32'd0;
        fmt_sh      = 5'd0;
        frame_sh    = {1'b0, (ch_reg == 2'd2)} + {1'b0, (bd_reg == 5'd16)};

        case (phase_reg)
            // riff header: tag, ignored size, wave tag
            PH_RIFF:
            begin
                cnt_next = pos + 4'd1;
                if (pos < 4'd4 || pos >= 4'd8)
                begin
                    tag_next = tag_acc;
                    if (pos == 4'd3 || pos == 4'd11)
                    begin
                        if (tag_acc != ((pos == 4'd3) ? TAG_RIFF : TAG_WAVE))
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            tag_next = 32'd0;
                            if (pos == 4'd11)
                            begin
                                phase_next = PH_CHUNK;
                                cnt_next   = 4'd0;
                            end
                        end
                    end
                end
            end

            // chunk header: tag then little-endian length
            PH_CHUNK:
            begin
                fs_acc   = fs_base | (b_wide << {pos[1:0], 3'b000});
                cnt_next = pos + 4'd1;
                if (pos < 4'd4)
                begin
                    tag_next = tag_base | (b_wide << {pos[1:0], 3'b000});
                    fs_next  = fs_base;
                end
                else
                begin
                    tag_next = tag_base;
                    fs_next  = fs_acc;
                end
                if (pos >= 4'd7)
                begin
                    rem_next = fs_acc;
                    cnt_next = 4'd0;
                    if (tag_base == TAG_FMT)
                    begin
                        phase_next = PH_FMT;
                    end
                    else if (tag_base == TAG_DATA)
                    begin
                        if (ch_reg == 2'd0 || bd_reg == 5'd0)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            budget_next = fs_acc >> frame_sh;
                            fpos_next   = 1'b0;
                            phase_next  = PH_DATA;
                            hdr         = 1'b1;
                        end
                    end
                    else if (fs_acc != 32'd0 && !fs_acc[31])
                    begin
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_CHUNK;
                    end
                end
            end

            // fmt body: format, channels, rate, byte rate, align, bits
            PH_FMT:
            begin
                if (pos >= 4'd4 && pos < 4'd8)
                begin
                    fmt_sh = {pos[1:0], 3'b000};
                end
                else
                begin
                    fmt_sh = {1'b0, pos[0], 3'b000};
                end
                if (pos == 4'd0 || pos == 4'd2 || pos == 4'd4 || pos == 4'd14)
                begin
                    fs_acc = b_wide << fmt_sh;
                end
                else
                begin
                    fs_acc = fs_reg | (b_wide << fmt_sh);
                end
                fs_next  = fs_acc;
                cnt_next = pos + 4'd1;
                if (pos == 4'd1 && fs_acc != 32'd1)
                begin
                    err = 1'b1;
                end
                if (pos == 4'd3)
                begin
                    if (fs_acc != 32'd1 && fs_acc != 32'd2)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        ch_next = fs_acc[1:0];
                    end
                end
                if (pos == 4'd7)
                begin
                    rate_next = fs_acc;
                end
                if (pos == 4'd15)
                begin
                    if (fs_acc != 32'd8 && fs_acc != 32'd16)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        bd_next  = fs_acc[4:0];
                        cnt_next = 4'd0;
                        if (!rem_reg[31] && rem_reg > 32'd16)
                        begin
                            rem_next   = rem_reg - 32'd16;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            phase_next = PH_CHUNK;
                        end
                    end
                end
            end

            // skip the body of an unknown chunk or the rest of a long fmt chunk
            PH_SKIP:
            begin
                rem_next = rem_reg - 32'd1;
                if (rem_reg == 32'd1)
                begin
                    phase_next = PH_CHUNK;
                    cnt_next   = 4'd0;
                end
            end

            // sample data until the frame budget is spent
            PH_DATA:
            begin
                if (budget_reg != 32'd0)
                begin
                    if (bd_reg == 5'd8)
                    begin
                        smp     = {b ^ PCM8_OFFSET, 8'd0};
                        smp_out = 1'b1;
                    end
                    else if (!cnt_reg[0])
                    begin
                        fs_next  = b_wide;
                        cnt_next = 4'd1;
                    end
                    else
                    begin
                        smp      = {b, fs_reg[7:0]};
                        cnt_next = 4'd0;
                        smp_out  = 1'b1;
                    end
                    // stereo: hold the left sample until the right one arrives
                    if (smp_out && ch_reg == 2'd2 && !fpos_reg)
                    begin
                        held_next = smp;
                        fpos_next = 1'b1;
                        smp_out   = 1'b0;
                    end
                    else if (smp_out)
                    begin
                        fpos_next   = 1'b0;
                        budget_next = budget_reg - 32'd1;
                    end
                end
            end

            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (err)
        begin
            phase_next = PH_FAIL;
        end

        // result beat
        res.kind             = err ? KIND_ERROR : (hdr ? KIND_HEADER : KIND_SAMPLE);
        res.left_sample      = 16'd0;
        res.right_sample     = 16'd0;
        if (smp_out && !err)
        begin
            res.left_sample  = (ch_reg == 2'd2) ? held_reg : smp;
            res.right_sample = (ch_reg == 2'd2) ? smp : 16'd0;
        end
        res.channels         = ch_next;
        res.bits_per_sample  = bd_next;
        res.sample_rate      = rate_next;
        res.frames_remaining = err ? 32'd0 : budget_next;

        // end of file: back to the header
        if (byte_chan.payload.last_byte)
        begin
            phase_next  = PH_RIFF;
            cnt_next    = 4'd0;
            tag_next    = 32'd0;
            rem_next    = 32'd0;
            fs_next     = 32'd0;
            ch_next     = 2'd0;
            bd_next     = 5'd0;
            rate_next   = 32'd0;
            budget_next = 32'd0;
            held_next   = 16'd0;
            fpos_next   = 1'b0;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RIFF;
            cnt_reg    <= 4'd0;
            tag_reg    <= 32'd0;
            rem_reg    <= 32'd0;
            fs_reg     <= 32'd0;
            ch_reg     <= 2'd0;
            bd_reg     <= 5'd0;
            rate_reg   <= 32'd0;
            budget_reg <= 32'd0;
            held_reg   <= 16'd0;
            fpos_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            tag_reg    <= tag_next;
            rem_reg    <= rem_next;
            fs_reg     <= fs_next;
            ch_reg     <= ch_next;
            bd_reg     <= bd_next;
            rate_reg   <= rate_next;
            budget_reg <= budget_next;
            held_reg   <= held_next;
            fpos_reg   <= fpos_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && (err || hdr || smp_out))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_chan.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (accept && (err || hdr || smp_out))
        begin
            out_reg <= res;
        end
    end

endmodule

@@ sv/wpsd_checker.sv @@
// wpsd_checker: port-level assertions for the wav pcm decoder, bound to the top
// depends on wpsd_pkg and wav_pcm_stream_decoder_unit
module wpsd_checker
    import wpsd_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         in_valid,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input wpsd_result_t out_payload
);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result beat changed while stalled");

    // input is never blocked while the result slot is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty result slot");

    // a result only shows up after an input beat was taken
    a_result_follows_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result beat without an input beat");

    // error results carry no samples and no frames
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.kind == KIND_ERROR |->
        out_payload.left_sample == 16'sd0 && out_payload.right_sample == 16'sd0 &&
        out_payload.frames_remaining == 32'd0)
        else $error("error result with payload");

    // sample frames only with a validated format, mono right channel zero
    a_sample_format: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.kind == KIND_SAMPLE |->
        (out_payload.bits_per_sample == 5'd8 || out_payload.bits_per_sample == 5'd16) &&
        (out_payload.channels == 2'd2 || out_payload.right_sample == 16'sd0))
        else $error("sample frame with bad format");

endmodule

bind wav_pcm_stream_decoder_unit wpsd_checker u_wpsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (byte_chan.valid),
    .in_ready    (byte_chan.ready),
    .out_valid   (result_chan.valid),
    .out_ready   (result_chan.ready),
    .out_payload (result_chan.payload)
);

@@ sim/testbench.sv @@
// testbench for wav_pcm_stream_decoder_unit: feeds whole wav files byte by byte and
// checks every result beat against a byte-level parser model kept in a scoreboard
// depends on wpsd_pkg, wpsd_stream_if and the decoder rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wpsd_pkg::*;

    // parser phases of the local model
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHUNK_HDR,
        PH_FMT_BODY,
        PH_SKIP_BODY,
        PH_SAMPLES,
        PH_FAILED
    } parse_phase_t;

    // fmt chunk field values
    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [1:0]  CH_MONO   = 2'd1;
    localparam logic [1:0]  CH_STEREO = 2'd2;
    localparam logic [4:0]  DEPTH_8   = 5'd8;
    localparam logic [4:0]  DEPTH_16  = 5'd16;

    // chunk tags the parser skips over
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;
    localparam logic [31:0] TAG_JUNK = 32'h6B6E_756A;

    // run shape
    localparam int RANDOM_BYTES   = 1300;
    localparam int LONG_HOLD      = 250;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 8;

    // expected results and the parser model that produces them
    class wav_result_scoreboard;
        wpsd_result_t awaited_results[$];
        int           mismatch_count;

        parse_phase_t phase;
        logic [31:0]  pos_count;
        logic [31:0]  tag_acc;
        logic [31:0]  chunk_left;
        logic [31:0]  field_acc;
        logic [1:0]   chan_count;
        logic [4:0]   depth;
        logic [31:0]  rate;
        logic [31:0]  frames_left;
        logic [15:0]  held_left;
        logic         frame_half;

        function new();
            mismatch_count = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase       = PH_HEADER;
            pos_count   = '0;
            tag_acc     = '0;
            chunk_left  = '0;
            field_acc   = '0;
            chan_count  = '0;
            depth       = '0;
            rate        = '0;
            frames_left = '0;
            held_left   = '0;
            frame_half  = 1'b0;
        endfunction

        function void push_result(logic [1:0] kind, logic [15:0] left, logic [15:0] right,
                                  logic [31:0] frames);
            wpsd_result_t res;
            res.kind             = kind;
            res.left_sample      = left;
            res.right_sample     = right;
            res.channels         = chan_count;
            res.bits_per_sample  = depth;
            res.sample_rate      = rate;
            res.frames_remaining = frames;
            awaited_results.push_back(res);
        endfunction

        function void fail_parse();
            phase = PH_FAILED;
            push_result(KIND_ERROR, '0, '0, '0);
        endfunction

        // leave a chunk: skip its remaining body unless empty or negative
        function void end_chunk(logic [31:0] skip);
            pos_count = '0;
            if (skip != 0 && !skip[31])
            begin
                chunk_left = skip;
                phase      = PH_SKIP_BODY;
            end
            else
            begin
                phase = PH_CHUNK_HDR;
            end
        endfunction

        function void decode_byte(logic [7:0] b);
            logic [31:0] pos;
            logic [31:0] want;
            logic [15:0] smp;
            int          shamt;
            pos = pos_count;
            case (phase)
                // riff tag, size word ignored, wave tag
                PH_HEADER:
                begin
                    pos_count = pos + 1;
                    if (pos < 4 || pos >= 8)
                    begin
                        tag_acc |= 32'(b) << (8 * pos[1:0]);
                        if (pos == 3 || pos == 11)
                        begin
                            want = (pos == 3) ? TAG_RIFF : TAG_WAVE;
                            if (tag_acc != want)
                            begin
                                fail_parse();
                                return;
                            end
                            tag_acc = '0;
                            if (pos == 11)
                            begin
                                phase     = PH_CHUNK_HDR;
                                pos_count = '0;
                            end
                        end
                    end
                end
                // tag then little-endian length
                PH_CHUNK_HDR:
                begin
                    if (pos == 0)
                    begin
                        tag_acc   = '0;
                        field_acc = '0;
                    end
                    if (pos < 4)
                        tag_acc |= 32'(b) << (8 * pos[1:0]);
                    else
                        field_acc |= 32'(b) << (8 * pos[1:0]);
                    pos_count = pos + 1;
                    if (pos < 7)
                        return;
                    chunk_left = field_acc;
                    pos_count  = '0;
                    if (tag_acc == TAG_FMT)
                    begin
                        phase = PH_FMT_BODY;
                    end
                    else if (tag_acc == TAG_DATA)
                    begin
                        if (chan_count == 0 || depth == 0)
                        begin
                            fail_parse();
                            return;
                        end
                        shamt = int'(chan_count == CH_STEREO) + int'(depth == DEPTH_16);
                        frames_left = chunk_left >> shamt;
                        frame_half  = 1'b0;
                        phase       = PH_SAMPLES;
                        push_result(KIND_HEADER, '0, '0, frames_left);
                    end
                    else
                    begin
                        end_chunk(chunk_left);
                    end
                end
                // sixteen fmt bytes, fields checked on their last byte
                PH_FMT_BODY:
                begin
                    if (pos == 0 || pos == 2 || pos == 4 || pos == 14)
                        field_acc = '0;
                    shamt = 8 * int'(pos[0]);
                    if (pos >= 4 && pos < 8)
                        shamt += 16 * int'((pos - 4) >> 1);
                    field_acc |= 32'(b) << shamt;
                    pos_count = pos + 1;
                    if (pos == 1 && field_acc != 32'(FMT_PCM))
                    begin
                        fail_parse();
                        return;
                    end
                    if (pos == 3)
                    begin
                        if (field_acc != 32'(CH_MONO) && field_acc != 32'(CH_STEREO))
                        begin
                            fail_parse();
                            return;
                        end
                        chan_count = field_acc[1:0];
                    end
                    if (pos == 7)
                        rate = field_acc;
                    if (pos == 15)
                    begin
                        if (field_acc != 32'(DEPTH_8) && field_acc != 32'(DEPTH_16))
                        begin
                            fail_parse();
                            return;
                        end
                        depth = field_acc[4:0];
                        end_chunk((!chunk_left[31] && chunk_left > 16) ? chunk_left - 16 : '0);
                    end
                end
                PH_SKIP_BODY:
                begin
                    chunk_left = chunk_left - 1;
                    if (chunk_left == 0)
                        end_chunk('0);
                end
                // samples, one result per whole frame while the budget lasts
                PH_SAMPLES:
                begin
                    if (frames_left == 0)
                        return;
                    if (depth == DEPTH_8)
                    begin
                        smp = {b ^ PCM8_OFFSET, 8'h00};
                    end
                    else if (!pos_count[0])
                    begin
                        field_acc = 32'(b);
                        pos_count = 32'd1;
                        return;
                    end
                    else
                    begin
                        smp       = {b, field_acc[7:0]};
                        pos_count = '0;
                    end
                    if (chan_count == CH_STEREO && !frame_half)
                    begin
                        held_left  = smp;
                        frame_half = 1'b1;
                        return;
                    end
                    frame_half  = 1'b0;
                    frames_left = frames_left - 1;
                    if (chan_count == CH_STEREO)
                        push_result(KIND_SAMPLE, held_left, smp, frames_left);
                    else
                        push_result(KIND_SAMPLE, smp, '0, frames_left);
                end
                default:
                begin
                end
            endcase
        endfunction

        // accepted input beat
        function void note_byte(wpsd_byte_t beat);
            decode_byte(beat.byte_value);
            if (beat.last_byte)
                clear_state();
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("%0t mismatch: %s", $realtime, what);
        endtask

        task compare_field(string name, logic [31:0] seen, logic [31:0] want);
            if (seen !== want)
                report_mismatch($sformatf("%s got %h want %h", name, seen, want));
        endtask

        // accepted result beat against the oldest expectation
        task check_result(wpsd_result_t got);
            wpsd_result_t want;
            if (awaited_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result beat, kind %0d", got.kind));
                return;
            end
            want = awaited_results.pop_front();
            compare_field("kind", 32'(got.kind), 32'(want.kind));
            compare_field("left_sample", 32'(got.left_sample), 32'(want.left_sample));
            compare_field("right_sample", 32'(got.right_sample), 32'(want.right_sample));
            compare_field("channels", 32'(got.channels), 32'(want.channels));
            compare_field("bits_per_sample", 32'(got.bits_per_sample),
                          32'(want.bits_per_sample));
            compare_field("sample_rate", got.sample_rate, want.sample_rate);
            compare_field("frames_remaining", got.frames_remaining, want.frames_remaining);
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wpsd_stream_if #(.payload_t(wpsd_byte_t))   byte_chan ();
    wpsd_stream_if #(.payload_t(wpsd_result_t)) result_chan ();

    wav_pcm_stream_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_chan   (byte_chan),
        .result_chan (result_chan)
    );

    wav_result_scoreboard sb = new();

    logic [7:0] file_bytes[$];
    int         burst_left     = 0;
    int         bytes_sent     = 0;
    int         results_taken  = 0;
    int         quiet_cycles   = 0;
    bit         long_hold_done = 1'b0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // beat monitor: results checked before the new byte is modeled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_chan.valid && result_chan.ready)
            begin
                sb.check_result(result_chan.payload);
                results_taken++;
            end
            if (byte_chan.valid && byte_chan.ready)
                sb.note_byte(byte_chan.payload);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (byte_chan.valid && byte_chan.ready)
                   || (result_chan.valid && result_chan.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: random stall modes, a rotating pattern and long hold-offs
    initial
    begin : receiver
        int          mode;
        int          seg;
        logic [15:0] stall_pattern;
        stall_pattern = 16'b1011_0011_1000_1101;
        result_chan.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ((!long_hold_done && results_taken >= 40) || $urandom_range(0, 40) == 0)
            begin
                @(negedge clk);
                result_chan.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(8, 80);
            repeat (seg)
            begin
                @(negedge clk);
                case (mode)
                    0: result_chan.ready = 1'b1;
                    1: result_chan.ready = ($urandom_range(0, 3) != 0);
                    2: result_chan.ready = ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        result_chan.ready = stall_pattern[0];
                        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                    end
                endcase
            end
        end
    end

    // one byte beat, sent in bursts with random gaps
    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                byte_chan.valid = 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge clk);
        byte_chan.valid   = 1'b1;
        byte_chan.payload = '{byte_value: value, last_byte: last};
        do
            @(posedge clk);
        while (!byte_chan.ready);
        burst_left--;
        bytes_sent++;
    endtask

    // whole file, last flag on the final byte
    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    // stop offering until every expected result is out
    task automatic drain_wait();
        @(negedge clk);
        byte_chan.valid = 1'b0;
        while (sb.awaited_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic void put_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(w[8 * i +: 8]);
    endfunction

    function automatic void put_half(logic [15:0] h);
        file_bytes.push_back(h[7:0]);
        file_bytes.push_back(h[15:8]);
    endfunction

    // random bytes, often the sample extremes
    function automatic void put_random_bytes(int n);
        logic [7:0] corner_bytes[4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                file_bytes.push_back(corner_bytes[$urandom_range(0, 3)]);
            else
                file_bytes.push_back(8'($urandom));
        end
    endfunction

    function automatic void put_riff();
        put_word(TAG_RIFF);
        put_word($urandom);
        put_word(TAG_WAVE);
    endfunction

    function automatic void put_chunk(logic [31:0] tag, logic [31:0] len);
        put_word(tag);
        put_word(len);
    endfunction

    // fmt chunk, padded when its length asks for more than 16 bytes
    function automatic void put_fmt(logic [15:0] code, logic [15:0] ch, logic [31:0] fs,
                                    logic [15:0] bits, logic [31:0] len);
        put_chunk(TAG_FMT, len);
        put_half(code);
        put_half(ch);
        put_word(fs);
        put_word($urandom);
        put_half(16'($urandom));
        put_half(bits);
        if (!len[31] && len > 16)
            put_random_bytes(int'(len - 16));
    endfunction

    // chunk the parser has to skip, sometimes with a negative length
    function automatic void put_side_chunk();
        logic [31:0] tag;
        int          len;
        case ($urandom_range(0, 2))
            0:       tag = TAG_LIST;
            1:       tag = TAG_JUNK;
            default: tag = $urandom;
        endcase
        if ($urandom_range(0, 7) == 0)
        begin
            put_chunk(tag, 32'h8000_0000 | 32'($urandom_range(0, 255)));
        end
        else
        begin
            len = $urandom_range(0, 6);
            put_chunk(tag, 32'(len));
            put_random_bytes(len);
        end
    endfunction

    // mostly well-formed files with random content, some broken or plain noise
    function automatic void build_random_file();
        int          style;
        int          frame_bytes;
        int          cut;
        logic [15:0] code;
        logic [15:0] ch;
        logic [15:0] bits;
        logic [31:0] fmt_len;
        logic [31:0] data_len;
        int          count;
        style = $urandom_range(0, 99);
        if (style < 8)
        begin
            put_random_bytes($urandom_range(1, 12));
            return;
        end
        put_riff();
        repeat ($urandom_range(0, 2)) put_side_chunk();
        code = FMT_PCM;
        ch   = ($urandom_range(0, 1) != 0) ? 16'(CH_STEREO) : 16'(CH_MONO);
        bits = ($urandom_range(0, 1) != 0) ? 16'(DEPTH_16) : 16'(DEPTH_8);
        // one fmt field randomized, possibly out of range
        if (style < 20)
        begin
            case ($urandom_range(0, 2))
                0:       code = 16'($urandom);
                1:       ch   = 16'($urandom_range(0, 3));
                default: bits = 16'($urandom_range(0, 24));
            endcase
        end
        case ($urandom_range(0, 7))
            0:       fmt_len = 32'($urandom_range(0, 15));
            1:       fmt_len = 32'(16 + $urandom_range(1, 5));
            default: fmt_len = 32'd16;
        endcase
        put_fmt(code, ch, $urandom, bits, fmt_len);
        // second fmt chunk replaces the first
        if ($urandom_range(0, 9) == 0)
        begin
            ch   = ($urandom_range(0, 1) != 0) ? 16'(CH_STEREO) : 16'(CH_MONO);
            bits = ($urandom_range(0, 1) != 0) ? 16'(DEPTH_16) : 16'(DEPTH_8);
            put_fmt(FMT_PCM, ch, $urandom, bits, 32'd16);
        end
        if ($urandom_range(0, 3) == 0)
            put_side_chunk();
        frame_bytes = ((ch == 16'(CH_STEREO)) ? 2 : 1) * ((bits == 16'(DEPTH_16)) ? 2 : 1);
        data_len = 32'($urandom_range(0, 12) * frame_bytes + $urandom_range(0, frame_bytes - 1));
        put_chunk(TAG_DATA, data_len);
        case ($urandom_range(0, 5))
            0:       count = int'(data_len) + $urandom_range(1, 4);
            1:       count = $urandom_range(0, int'(data_len));
            default: count = int'(data_len);
        endcase
        put_random_bytes(count);
        // flip a header byte
        if (style >= 20 && style < 30)
        begin
            cut = (file_bytes.size() < 44) ? file_bytes.size() : 44;
            file_bytes[$urandom_range(0, cut - 1)] ^= 8'($urandom_range(1, 255));
        end
        // end the file early
        if (style >= 30 && style < 35)
        begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
    endfunction

    // main stimulus
    initial
    begin
        byte_chan.valid   = 1'b0;
        byte_chan.payload = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // bad riff tag, rest of the file ignored
        put_word(TAG_RIFF ^ 32'h0100_0000);
        put_random_bytes(3);
        send_file();
        // bad wave tag
        put_word(TAG_RIFF);
        put_word(32'hFFFF_FFFF);
        put_word(TAG_WAVE ^ 32'h8000_0000);
        send_file();
        // data chunk ahead of fmt
        put_riff();
        put_chunk(TAG_DATA, 32'd4);
        put_random_bytes(4);
        send_file();
        // each fmt field out of range
        put_riff();
        put_fmt(16'd3, 16'(CH_MONO), $urandom, 16'(DEPTH_8), 32'd16);
        send_file();
        put_riff();
        put_fmt(FMT_PCM, 16'd0, $urandom, 16'(DEPTH_8), 32'd16);
        send_file();
        put_riff();
        put_fmt(FMT_PCM, 16'd3, $urandom, 16'(DEPTH_8), 32'd16);
        send_file();
        put_riff();
        put_fmt(FMT_PCM, 16'(CH_STEREO), $urandom, 16'd24, 32'd16);
        send_file();
        // mono 8-bit, zero rate, extreme codes, bytes past the budget
        put_riff();
        put_fmt(FMT_PCM, 16'(CH_MONO), 32'd0, 16'(DEPTH_8), 32'd16);
        put_chunk(TAG_DATA, 32'd4);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h7F);
        file_bytes.push_back(8'h80);
        file_bytes.push_back(8'hFF);
        put_random_bytes(2);
        send_file();
        // stereo 16-bit, padded fmt, odd-length skipped chunk, extreme samples
        put_riff();
        put_fmt(FMT_PCM, 16'(CH_STEREO), 32'hFFFF_FFFF, 16'(DEPTH_16), 32'd20);
        put_chunk(TAG_LIST, 32'd3);
        put_random_bytes(3);
        put_chunk(TAG_DATA, 32'd8);
        put_half(16'h8000);
        put_half(16'h7FFF);
        put_half(16'h0000);
        put_half(16'hFFFF);
        put_random_bytes(3);
        send_file();
        // short fmt length, data length with top bit set, partial frame at the end
        put_riff();
        put_fmt(FMT_PCM, 16'(CH_MONO), 32'd44100, 16'(DEPTH_16), 32'd4);
        put_chunk(TAG_DATA, 32'h8000_0001);
        put_random_bytes(5);
        send_file();
        // negative lengths skip nothing, second fmt overrides, empty data chunk
        put_riff();
        put_chunk(TAG_JUNK, 32'h8000_0000);
        put_fmt(FMT_PCM, 16'(CH_STEREO), 32'd8000, 16'(DEPTH_8), 32'hFFFF_FFF0);
        put_fmt(FMT_PCM, 16'(CH_MONO), 32'd48000, 16'(DEPTH_16), 32'd16);
        put_chunk(TAG_DATA, 32'd0);
        put_random_bytes(2);
        send_file();
        // file cut off inside a chunk header
        put_riff();
        put_chunk(TAG_LIST, 32'd0);
        put_word(TAG_FMT);
        send_file();
        // one-byte file
        put_random_bytes(1);
        send_file();
        drain_wait();

        // random files
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            build_random_file();
            send_file();
            if ($urandom_range(0, 9) == 0)
                drain_wait();
        end

        drain_wait();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
sv/wpsd_pkg.sv
sv/wpsd_stream_if.sv
sv/wav_pcm_stream_decoder_unit.sv
sv/wpsd_checker.sv
sim/testbench.sv
